// ----- rtl/core/lsc_pkg.sv -----
// Shared types, constants and helper functions for the line segment clipper.
// No dependencies; every other file in rtl/core uses it.
`default_nettype none
package lsc_pkg;

    localparam int COORD_WIDTH    = 16;
    localparam int FRACTION_BITS  = 4;
    localparam int DIFF_W         = COORD_WIDTH + 1;
    localparam int MAG_W          = COORD_WIDTH;
    localparam int PROD_W         = 2 * COORD_WIDTH;
    localparam int SUM_W          = PROD_W + 2;
    localparam int DIV_CNT_W      = $clog2(PROD_W);
    localparam int MAX_CLIP_STEPS = 4;
    localparam int STEP_W         = $clog2(MAX_CLIP_STEPS + 1);
    localparam int FIFO_DEPTH     = 2;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W      = 2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic        [MAG_W-1:0]       t_mag;
    typedef logic        [3:0]             t_code;

    localparam t_code CODE_LEFT   = 4'b0001;
    localparam t_code CODE_RIGHT  = 4'b0010;
    localparam t_code CODE_BOTTOM = 4'b0100;
    localparam t_code CODE_TOP    = 4'b1000;

    localparam t_coord WIN_LO_RESET = t_coord'(-(100 * (1 << FRACTION_BITS)));
    localparam t_coord WIN_HI_RESET = t_coord'(100 * (1 << FRACTION_BITS));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT   = 2'd0,
        CFG_BOTTOM = 2'd1,
        CFG_RIGHT  = 2'd2,
        CFG_TOP    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_coord left;
        t_coord bottom;
        t_coord right;
        t_coord top;
    } t_win;

    typedef struct packed {
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
        t_code  c0;
        t_code  c1;
    } t_seg;

    typedef struct packed {
        logic push;
        logic full;
    } t_push;

    typedef struct packed {
        logic pop;
        logic empty;
    } t_pop;

    function automatic t_code outcode(t_coord x, t_coord y, t_win w);
        t_code c;
        c = '0;
        if (x < w.left) begin
            c = c | CODE_LEFT;
        end else if (x > w.right) begin
            c = c | CODE_RIGHT;
        end
        if (y < w.bottom) begin
            c = c | CODE_BOTTOM;
        end else if (y > w.top) begin
            c = c | CODE_TOP;
        end
        return c;
    endfunction

    function automatic t_diff sub(t_coord a, t_coord b);
        t_diff ea;
        t_diff eb;
        ea = {a[COORD_WIDTH-1], a};
        eb = {b[COORD_WIDTH-1], b};
        return ea - eb;
    endfunction

    function automatic t_mag mag(t_diff v);
        t_diff nv;
        nv = -v;
        return v[DIFF_W-1] ? nv[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lsc_front.sv -----
// Front end: takes input words and computes the initial region codes.
// Depends on lsc_pkg.
`default_nettype none
module lsc_front (
    input  wire            i_valid,
    output logic           o_stall,
    input  lsc_pkg::t_coord i_start_x,
    input  lsc_pkg::t_coord i_start_y,
    input  lsc_pkg::t_coord i_end_x,
    input  lsc_pkg::t_coord i_end_y,
    input  lsc_pkg::t_win  i_win,
    input  logic           i_full,
    output lsc_pkg::t_push o_push,
    output lsc_pkg::t_seg  o_seg
);

    always_comb begin
        o_stall     = i_full;
        o_push.push = i_valid && !i_full;
        o_push.full = i_full;
        o_seg.x0    = i_start_x;
        o_seg.y0    = i_start_y;
        o_seg.x1    = i_end_x;
        o_seg.y1    = i_end_y;
        o_seg.c0    = lsc_pkg::outcode(i_start_x, i_start_y, i_win);
        o_seg.c1    = lsc_pkg::outcode(i_end_x, i_end_y, i_win);
    end

endmodule
`default_nettype wire

// ----- rtl/core/lsc_fifo.sv -----
// Short queue of classified segments between front and back ends.
// Depends on lsc_pkg.
`default_nettype none
module lsc_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  lsc_pkg::t_push i_push,
    input  lsc_pkg::t_seg  i_seg,
    output logic           o_full,
    input  lsc_pkg::t_pop  i_pop,
    output logic           o_empty,
    output lsc_pkg::t_seg  o_seg
);

    lsc_pkg::t_seg                r_mem [lsc_pkg::FIFO_DEPTH];
    logic [lsc_pkg::FIFO_AW-1:0]  r_wp, n_wp;
    logic [lsc_pkg::FIFO_AW-1:0]  r_rp, n_rp;
    logic [lsc_pkg::FIFO_AW:0]    r_cnt, n_cnt;

    always_comb begin
        o_full  = (r_cnt == (lsc_pkg::FIFO_AW+1)'(lsc_pkg::FIFO_DEPTH));
        o_empty = (r_cnt == '0);
        o_seg   = r_mem[r_rp];
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_cnt   = r_cnt;
        if (i_push.push) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop.pop) begin
            n_rp = r_rp + 1'b1;
        end
        if (i_push.push && !i_pop.pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push.push && i_pop.pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wp] <= i_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/lsc_div.sv -----
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on lsc_pkg.
`default_nettype none
module lsc_div (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  logic                        i_start,
    input  logic [lsc_pkg::PROD_W-1:0]  i_dividend,
    input  lsc_pkg::t_mag               i_divisor,
    output logic                        o_done,
    output logic [lsc_pkg::PROD_W-1:0]  o_quot
);

    logic                           r_busy;
    logic                           r_done;
    logic [lsc_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [lsc_pkg::PROD_W-1:0]     r_dq;
    lsc_pkg::t_mag                  r_rem;
    lsc_pkg::t_mag                  r_dsr;
    logic [lsc_pkg::MAG_W:0]        rem_sh;
    logic [lsc_pkg::MAG_W:0]        rem_sub;
    logic                           take;

    always_comb begin
        rem_sh  = {r_rem, r_dq[lsc_pkg::PROD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dsr};
        take    = (rem_sh >= {1'b0, r_dsr});
        o_done  = r_done;
        o_quot  = r_dq;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dq  <= {r_dq[lsc_pkg::PROD_W-2:0], take};
            r_rem <= take ? rem_sub[lsc_pkg::MAG_W-1:0] : rem_sh[lsc_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= lsc_pkg::DIV_CNT_W'(lsc_pkg::PROD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/lsc_back.sv -----
// Back end: clip-step sequencer with multiplier, divider and output register.
// Depends on lsc_pkg and lsc_div.
`default_nettype none
module lsc_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  lsc_pkg::t_win  i_win,
    input  logic           i_empty,
    input  lsc_pkg::t_seg  i_seg,
    output lsc_pkg::t_pop  o_pop,
    output logic           o_valid,
    input  wire            i_stall,
    output logic           o_accepted,
    output lsc_pkg::t_coord o_clip_start_x,
    output lsc_pkg::t_coord o_clip_start_y,
    output lsc_pkg::t_coord o_clip_end_x,
    output lsc_pkg::t_coord o_clip_end_y
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_TEST = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIVS = 6'b001000,
        ST_DIVW = 6'b010000,
        ST_UPD  = 6'b100000
    } t_state;

    t_state                         r_state, n_state;
    lsc_pkg::t_seg                  r_seg;
    logic [lsc_pkg::STEP_W-1:0]     r_step;
    lsc_pkg::t_mag                  r_ua, r_ub, r_ud;
    logic                           r_neg;
    logic                           r_ymove;
    lsc_pkg::t_coord                r_base, r_fixed;
    logic [lsc_pkg::PROD_W-1:0]     r_prod, r_q;
    logic                           r_ovalid, r_acc;
    lsc_pkg::t_coord                r_ox0, r_oy0, r_ox1, r_oy1;

    lsc_pkg::t_code                 co, or_c, and_c;
    lsc_pkg::t_diff                 da, db, dd;
    lsc_pkg::t_coord                base, fixed;
    logic                           ymove;
    logic                           finish;
    logic                           out_free;
    logic                           div_done;
    logic [lsc_pkg::PROD_W-1:0]     div_q;
    logic signed [lsc_pkg::SUM_W-1:0] sum, base_ext, q_ext;
    lsc_pkg::t_coord                res, nx, ny;
    logic signed [lsc_pkg::SUM_W-1:0] hi_lim, lo_lim;

    lsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_DIVS),
        .i_dividend (r_prod),
        .i_divisor  (r_ud),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_comb begin
        or_c     = r_seg.c0 | r_seg.c1;
        and_c    = r_seg.c0 & r_seg.c1;
        co       = (r_seg.c0 != '0) ? r_seg.c0 : r_seg.c1;
        finish   = (or_c == '0) || (and_c != '0)
                   || (r_step == lsc_pkg::STEP_W'(lsc_pkg::MAX_CLIP_STEPS));
        out_free = !r_ovalid || !i_stall;
        priority if ((co & lsc_pkg::CODE_TOP) != '0) begin
            da = lsc_pkg::sub(r_seg.x1, r_seg.x0);
            db = lsc_pkg::sub(i_win.top, r_seg.y0);
            dd = lsc_pkg::sub(r_seg.y1, r_seg.y0);
            base = r_seg.x0; fixed = i_win.top; ymove = 1'b0;
        end else if ((co & lsc_pkg::CODE_BOTTOM) != '0) begin
            da = lsc_pkg::sub(r_seg.x1, r_seg.x0);
            db = lsc_pkg::sub(i_win.bottom, r_seg.y0);
            dd = lsc_pkg::sub(r_seg.y1, r_seg.y0);
            base = r_seg.x0; fixed = i_win.bottom; ymove = 1'b0;
        end else if ((co & lsc_pkg::CODE_RIGHT) != '0) begin
            da = lsc_pkg::sub(r_seg.y1, r_seg.y0);
            db = lsc_pkg::sub(i_win.right, r_seg.x0);
            dd = lsc_pkg::sub(r_seg.x1, r_seg.x0);
            base = r_seg.y0; fixed = i_win.right; ymove = 1'b1;
        end else begin
            da = lsc_pkg::sub(r_seg.y1, r_seg.y0);
            db = lsc_pkg::sub(i_win.left, r_seg.x0);
            dd = lsc_pkg::sub(r_seg.x1, r_seg.x0);
            base = r_seg.y0; fixed = i_win.left; ymove = 1'b1;
        end

        base_ext = lsc_pkg::SUM_W'(r_base);
        q_ext    = {2'b00, r_q};
        sum      = r_neg ? base_ext - q_ext : base_ext + q_ext;
        hi_lim   = lsc_pkg::SUM_W'(lsc_pkg::t_coord'({1'b0, {(lsc_pkg::COORD_WIDTH-1){1'b1}}}));
        lo_lim   = lsc_pkg::SUM_W'(lsc_pkg::t_coord'({1'b1, {(lsc_pkg::COORD_WIDTH-1){1'b0}}}));
        if (sum > hi_lim) begin
            res = hi_lim[lsc_pkg::COORD_WIDTH-1:0];
        end else if (sum < lo_lim) begin
            res = lo_lim[lsc_pkg::COORD_WIDTH-1:0];
        end else begin
            res = sum[lsc_pkg::COORD_WIDTH-1:0];
        end
        nx = r_ymove ? r_fixed : res;
        ny = r_ymove ? res : r_fixed;

        o_pop.pop   = (r_state == ST_IDLE) && !i_empty;
        o_pop.empty = i_empty;

        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_empty) n_state = ST_TEST;
            ST_TEST: begin
                if (finish) begin
                    if (out_free) n_state = ST_IDLE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = (r_ud == '0) ? ST_UPD : ST_DIVS;
            ST_DIVS: n_state = ST_DIVW;
            ST_DIVW: if (div_done) n_state = ST_UPD;
            ST_UPD:  n_state = ST_TEST;
            default: n_state = ST_IDLE;
        endcase

        o_valid        = r_ovalid;
        o_accepted     = r_acc;
        o_clip_start_x = r_ox0;
        o_clip_start_y = r_oy0;
        o_clip_end_x   = r_ox1;
        o_clip_end_y   = r_oy1;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_seg  <= i_seg;
                r_step <= '0;
            end
            ST_TEST: begin
                r_ua    <= lsc_pkg::mag(da);
                r_ub    <= lsc_pkg::mag(db);
                r_ud    <= lsc_pkg::mag(dd);
                r_neg   <= da[lsc_pkg::DIFF_W-1] ^ db[lsc_pkg::DIFF_W-1] ^ dd[lsc_pkg::DIFF_W-1];
                r_base  <= base;
                r_fixed <= fixed;
                r_ymove <= ymove;
                if (finish && out_free) begin
                    r_acc <= (or_c == '0);
                    r_ox0 <= r_seg.x0;
                    r_oy0 <= r_seg.y0;
                    r_ox1 <= r_seg.x1;
                    r_oy1 <= r_seg.y1;
                end
            end
            ST_MUL: begin
                r_prod <= lsc_pkg::PROD_W'(r_ua) * lsc_pkg::PROD_W'(r_ub);
                r_q    <= '0;
            end
            ST_DIVS: begin
            end
            ST_DIVW: begin
                if (div_done) r_q <= div_q;
            end
            ST_UPD: begin
                r_step <= r_step + 1'b1;
                if (r_seg.c0 != '0) begin
                    r_seg.x0 <= nx;
                    r_seg.y0 <= ny;
                    r_seg.c0 <= lsc_pkg::outcode(nx, ny, i_win);
                end else begin
                    r_seg.x1 <= nx;
                    r_seg.y1 <= ny;
                    r_seg.c1 <= lsc_pkg::outcode(nx, ny, i_win);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_TEST && finish && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/line_segment_clipper.sv -----
// Cohen-Sutherland line clipper against a window held in four registers.
// Each word passes the front end, the queue, the IDLE and TEST states of the back
// end and the output register; each clip step (at most four) adds MUL, the
// bit-serial divider unless the denominator is zero, and UPD. The two-entry queue
// and output register let input and output stall apart. Synchronous active-low
// reset sets the window to +/-100.0 and empties the queue and output register.
`default_nettype none
module line_segment_clipper (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire  [lsc_pkg::COORD_WIDTH-1:0] i_start_x,
    input  wire  [lsc_pkg::COORD_WIDTH-1:0] i_start_y,
    input  wire  [lsc_pkg::COORD_WIDTH-1:0] i_end_x,
    input  wire  [lsc_pkg::COORD_WIDTH-1:0] i_end_y,
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic                            o_accepted,
    output logic [lsc_pkg::COORD_WIDTH-1:0] o_clip_start_x,
    output logic [lsc_pkg::COORD_WIDTH-1:0] o_clip_start_y,
    output logic [lsc_pkg::COORD_WIDTH-1:0] o_clip_end_x,
    output logic [lsc_pkg::COORD_WIDTH-1:0] o_clip_end_y,
    input  wire                             i_cfg_we,
    input  wire  [lsc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [lsc_pkg::COORD_WIDTH-1:0] i_cfg_data
);

    lsc_pkg::t_win   r_win;
    lsc_pkg::t_push  push;
    lsc_pkg::t_pop   pop;
    lsc_pkg::t_seg   seg_in, seg_out;
    logic            full, empty;
    lsc_pkg::t_coord csx, csy, cex, cey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.left   <= lsc_pkg::WIN_LO_RESET;
            r_win.bottom <= lsc_pkg::WIN_LO_RESET;
            r_win.right  <= lsc_pkg::WIN_HI_RESET;
            r_win.top    <= lsc_pkg::WIN_HI_RESET;
        end else if (i_cfg_we) begin
            unique case (lsc_pkg::t_cfg_idx'(i_cfg_idx))
                lsc_pkg::CFG_LEFT:   r_win.left   <= i_cfg_data;
                lsc_pkg::CFG_BOTTOM: r_win.bottom <= i_cfg_data;
                lsc_pkg::CFG_RIGHT:  r_win.right  <= i_cfg_data;
                lsc_pkg::CFG_TOP:    r_win.top    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lsc_front u_front (
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_win     (r_win),
        .i_full    (full),
        .o_push    (push),
        .o_seg     (seg_in)
    );

    lsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_seg   (seg_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_seg   (seg_out)
    );

    lsc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_win          (r_win),
        .i_empty        (empty),
        .i_seg          (seg_out),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_accepted     (o_accepted),
        .o_clip_start_x (csx),
        .o_clip_start_y (csy),
        .o_clip_end_x   (cex),
        .o_clip_end_y   (cey)
    );

    assign o_clip_start_x = csx;
    assign o_clip_start_y = csy;
    assign o_clip_end_x   = cex;
    assign o_clip_end_y   = cey;

endmodule
`default_nettype wire

// ----- bench/line_segment_clipper_tb.sv -----
// Self-checking bench for line_segment_clipper: random and directed segments
// clipped against several windows, checked against a behavioural clipper.
// Depends on lsc_pkg and the line_segment_clipper RTL.
`default_nettype none
module line_segment_clipper_tb;

    typedef struct packed {
        lsc_pkg::t_coord x0;
        lsc_pkg::t_coord y0;
        lsc_pkg::t_coord x1;
        lsc_pkg::t_coord y1;
    } t_line;

    typedef struct packed {
        logic            acc;
        lsc_pkg::t_coord x0;
        lsc_pkg::t_coord y0;
        lsc_pkg::t_coord x1;
        lsc_pkg::t_coord y1;
    } t_clip;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    lsc_pkg::t_coord i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_accepted;
    logic [lsc_pkg::COORD_WIDTH-1:0] o_clip_start_x, o_clip_start_y;
    logic [lsc_pkg::COORD_WIDTH-1:0] o_clip_end_x, o_clip_end_y;
    logic i_cfg_we = 1'b0;
    lsc_pkg::t_cfg_idx i_cfg_idx = lsc_pkg::CFG_LEFT;
    lsc_pkg::t_coord i_cfg_data = '0;

    t_line pending_lines[$];
    t_clip expected_clips[$];
    longint win_l, win_b, win_r, win_t;
    int errors = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_phase = 0;
    bit in_wait = 0;

    line_segment_clipper u_top (.*);

    always #2 i_clk = ~i_clk;

    function automatic logic [3:0] region(longint x, longint y);
        logic [3:0] c;
        c = '0;
        if (x < win_l) c |= lsc_pkg::CODE_LEFT;
        else if (x > win_r) c |= lsc_pkg::CODE_RIGHT;
        if (y < win_b) c |= lsc_pkg::CODE_BOTTOM;
        else if (y > win_t) c |= lsc_pkg::CODE_TOP;
        return c;
    endfunction

    function automatic longint crossing(longint base, longint a, longint b, longint d);
        logic signed [127:0] prod;
        logic [127:0] mp, md, q;
        longint r;
        if (d == 0) return base;
        prod = 128'(signed'(a)) * 128'(signed'(b));
        mp = prod[127] ? -prod : prod;
        md = d < 0 ? 128'(-d) : 128'(d);
        q = mp / md;
        if (q > (128'd1 << 62)) q = 128'd1 << 62;
        r = ((prod[127]) != (d < 0)) ? base - longint'(q) : base + longint'(q);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic t_clip clip_line(t_line s);
        longint x0, y0, x1, y1, nx, ny;
        logic [3:0] c0, c1, co;
        t_clip res;
        x0 = s.x0; y0 = s.y0; x1 = s.x1; y1 = s.y1;
        c0 = region(x0, y0);
        c1 = region(x1, y1);
        for (int k = 0; k < lsc_pkg::MAX_CLIP_STEPS; k++) begin
            if ((c0 | c1) == 0 || (c0 & c1) != 0) break;
            co = c0 != 0 ? c0 : c1;
            if (co & lsc_pkg::CODE_TOP) begin
                nx = crossing(x0, x1 - x0, win_t - y0, y1 - y0); ny = win_t;
            end else if (co & lsc_pkg::CODE_BOTTOM) begin
                nx = crossing(x0, x1 - x0, win_b - y0, y1 - y0); ny = win_b;
            end else if (co & lsc_pkg::CODE_RIGHT) begin
                ny = crossing(y0, y1 - y0, win_r - x0, x1 - x0); nx = win_r;
            end else begin
                ny = crossing(y0, y1 - y0, win_l - x0, x1 - x0); nx = win_l;
            end
            if (c0 != 0) begin
                x0 = nx; y0 = ny; c0 = region(x0, y0);
            end else begin
                x1 = nx; y1 = ny; c1 = region(x1, y1);
            end
        end
        res.acc = (c0 | c1) == 0;
        res.x0 = lsc_pkg::t_coord'(x0); res.y0 = lsc_pkg::t_coord'(y0);
        res.x1 = lsc_pkg::t_coord'(x1); res.y1 = lsc_pkg::t_coord'(y1);
        return res;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_wait) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
                end
                if (burst_left > 0 && gap_left == 0 && pending_lines.size() > 0) begin
                    i_valid <= 1'b1;
                    i_start_x <= pending_lines[0].x0;
                    i_start_y <= pending_lines[0].y0;
                    i_end_x <= pending_lines[0].x1;
                    i_end_y <= pending_lines[0].y1;
                    void'(pending_lines.pop_front());
                    burst_left--;
                end else begin
                    i_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end
            stall_phase = (stall_phase + 1) % 64;
            i_stall <= (stall_phase < 24) ? 1'b0 : ($urandom_range(0, 2) == 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_clip want;
        in_wait = i_rst_n && i_valid && o_stall;
        if (i_rst_n && i_valid && !o_stall)
            expected_clips.push_back(clip_line({i_start_x, i_start_y, i_end_x, i_end_y}));
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_clips.size() == 0) begin
                $display("%0t unexpected word: acc=%b", $time, o_accepted);
                errors++;
            end else begin
                want = expected_clips.pop_front();
                if (want != {o_accepted, o_clip_start_x, o_clip_start_y,
                             o_clip_end_x, o_clip_end_y}) begin
                    $display("%0t expected %b %0d %0d %0d %0d got %b %0d %0d %0d %0d",
                        $time, want.acc, want.x0, want.y0, want.x1, want.y1,
                        o_accepted, $signed(o_clip_start_x), $signed(o_clip_start_y),
                        $signed(o_clip_end_x), $signed(o_clip_end_y));
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        wait (pending_lines.size() == 0);
        @(negedge i_clk);
        while (i_valid || expected_clips.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_window(longint l, longint b, longint r, longint t);
        lsc_pkg::t_coord vals[4];
        vals = '{lsc_pkg::t_coord'(l), lsc_pkg::t_coord'(b),
                 lsc_pkg::t_coord'(r), lsc_pkg::t_coord'(t)};
        for (int k = 0; k < 4; k++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= lsc_pkg::t_cfg_idx'(k);
            i_cfg_data <= vals[k];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        win_l = l; win_b = b; win_r = r; win_t = t;
    endtask

    function automatic lsc_pkg::t_coord rand_coord(int spread);
        case ($urandom_range(0, 5))
            0: return lsc_pkg::t_coord'($urandom);
            1: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            default: return lsc_pkg::t_coord'($signed($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    task automatic add_random(int n, int spread);
        repeat (n)
            pending_lines.push_back({rand_coord(spread), rand_coord(spread),
                                     rand_coord(spread), rand_coord(spread)});
    endtask

    initial begin
        win_l = -1600; win_b = -1600; win_r = 1600; win_t = 1600;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: inside, trivial reject, each edge, corners, extremes
        pending_lines.push_back({16'sd0, 16'sd0, 16'sd100, -16'sd100});
        pending_lines.push_back({-16'sd2000, 16'sd0, -16'sd1700, 16'sd500});
        pending_lines.push_back({16'sd0, 16'sd0, 16'sd3000, 16'sd0});
        pending_lines.push_back({16'sd0, 16'sd0, -16'sd3000, 16'sd10});
        pending_lines.push_back({16'sd5, 16'sd3000, 16'sd0, 16'sd0});
        pending_lines.push_back({16'sd7, -16'sd3000, 16'sd0, 16'sd0});
        pending_lines.push_back({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
        pending_lines.push_back({16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
        pending_lines.push_back({-16'sd3000, 16'sd1700, 16'sd1700, -16'sd3000});
        pending_lines.push_back({-16'sd1700, 16'sd0, 16'sd0, 16'sd1700});
        pending_lines.push_back({16'sd1600, 16'sd1600, -16'sd1600, -16'sd1600});
        pending_lines.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        add_random(400, 4000);
        drain();

        write_window(-32768, -32768, 32767, 32767);
        add_random(300, 32767);
        drain();

        write_window(0, 0, 0, 0);
        add_random(200, 50);
        drain();

        // inverted window, with a vertical and a horizontal segment
        write_window(500, 300, -500, -300);
        pending_lines.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd1000});
        pending_lines.push_back({16'sd0, 16'sd0, 16'sd1000, 16'sd0});
        add_random(300, 1500);
        drain();

        write_window(-16, -320, 700, 48);
        add_random(400, 2000);
        drain();

        write_window(32767, 32767, -32768, -32768);
        add_random(100, 32767);
        drain();

        write_window(-1600, -1600, 1600, 1600);
        add_random(300, 3000);
        drain();

        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
